// ===== src/fpa_pkg.sv =====
package fpa_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;
    localparam int DATA_W = 32;
    localparam int OP_W = 4;
    localparam int QUO_W = 64;
    localparam int QUO_BITS_PER_CELL = 2;
    localparam int NUM_CELLS = QUO_W / QUO_BITS_PER_CELL;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } opcode_t;

    // Payload that travels down the divider chain with each beat.
    typedef struct packed {
        logic                    valid;
        logic                    is_div;
        logic                    neg;
        logic                    dz;
        logic                    cmp;
        logic [DATA_W-1:0]       res;
        logic [QUO_W-1:0]        rem;
        logic [QUO_W-1:0]        num;
        logic [DATA_W-1:0]       den;
    } cell_t;

endpackage

// ===== src/fpa_cell.sv =====
module fpa_cell
    import fpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  cell_t cell_in,
    output cell_t cell_out
);

    cell_t cell_reg;
    cell_t cell_next;

    // Two restoring division steps: shift in one dividend bit, try to subtract.
    always_comb
    begin
        logic [QUO_W:0] trial;
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] num;
        cell_next = cell_in;
        rem = cell_in.rem;
        num = cell_in.num;
        for (int i = 0; i < QUO_BITS_PER_CELL; i++)
        begin
            rem = {rem[QUO_W-2:0], num[QUO_W-1]};
            num = {num[QUO_W-2:0], 1'b0};
            trial = {1'b0, rem} - {{(QUO_W-DATA_W+1){1'b0}}, cell_in.den};
            if (!trial[QUO_W])
            begin
                rem = trial[QUO_W-1:0];
                num[0] = 1'b1;
            end
        end
        cell_next.rem = rem;
        cell_next.num = num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== src/fpa_front.sv =====
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output cell_t                    cell_out
);

    // Stage one registers the operands and the product; stage two finishes.
    logic                            s1_valid_reg;
    logic [OP_W-1:0]                 s1_op_reg;
    logic signed [DATA_W-1:0]        s1_a_reg;
    logic signed [DATA_W-1:0]        s1_b_reg;
    logic signed [2*DATA_W-1:0]      s1_prod_reg;
    logic signed [2*DATA_W-1:0]      prod_next;
    cell_t                           cell_next;
    cell_t                           cell_reg;

    assign prod_next = 64'(operand_a) * 64'(operand_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= opcode;
            s1_a_reg    <= operand_a;
            s1_b_reg    <= operand_b;
            s1_prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        logic signed [2*DATA_W-1:0] prod_sh;
        logic [DATA_W-1:0] abs_a;
        logic [DATA_W-1:0] abs_b;
        logic lt;
        logic gt;
        prod_sh = s1_prod_reg >>> FRAC_BITS;
        abs_a = s1_a_reg[DATA_W-1] ? DATA_W'(-s1_a_reg) : DATA_W'(s1_a_reg);
        abs_b = s1_b_reg[DATA_W-1] ? DATA_W'(-s1_b_reg) : DATA_W'(s1_b_reg);
        lt = s1_a_reg < s1_b_reg;
        gt = s1_a_reg > s1_b_reg;
        cell_next = '0;
        cell_next.valid = s1_valid_reg;
        cell_next.den = abs_b;
        cell_next.num = {{(QUO_W-DATA_W){1'b0}}, abs_a} << FRAC_BITS;
        cell_next.neg = s1_a_reg[DATA_W-1] ^ s1_b_reg[DATA_W-1];
        unique case (opcode_t'(s1_op_reg))
            OP_ADD:      cell_next.res = s1_a_reg + s1_b_reg;
            OP_SUB:      cell_next.res = s1_a_reg - s1_b_reg;
            OP_MUL:      cell_next.res = prod_sh[DATA_W-1:0];
            OP_DIV:
            begin
                cell_next.is_div = (s1_b_reg != '0);
                cell_next.dz = (s1_b_reg == '0);
            end
            OP_GT:       cell_next.cmp = gt;
            OP_LT:       cell_next.cmp = lt;
            OP_GE:       cell_next.cmp = !lt;
            OP_LE:       cell_next.cmp = !gt;
            OP_EQ:       cell_next.cmp = (s1_a_reg == s1_b_reg);
            OP_NE:       cell_next.cmp = (s1_a_reg != s1_b_reg);
            OP_MIN:      cell_next.res = lt ? s1_a_reg : s1_b_reg;
            OP_MAX:      cell_next.res = gt ? s1_a_reg : s1_b_reg;
            OP_INC:      cell_next.res = s1_a_reg + DATA_W'(1);
            OP_DEC:      cell_next.res = s1_a_reg - DATA_W'(1);
            OP_FROM_INT: cell_next.res = s1_a_reg << FRAC_BITS;
            OP_TO_INT:   cell_next.res = s1_a_reg >>> FRAC_BITS;
            default:     cell_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== src/fixed_point_alu.sv =====
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits. One beat is
// accepted every cycle while the pipeline advances, and each beat gives
// exactly one result beat, in order. Two front stages register the operands
// and the 32x32 product and evaluate all non-divide opcodes, then every beat
// walks a chain of 32 cells that each retire two quotient bits of the 64-bit
// restoring divide, and a final output register holds the result. The whole
// pipeline advances whenever the output register is empty or being taken, so
// a stall on the output freezes the chain and in turn the input.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     compare_true,
    output logic                     divide_by_zero
);

    cell_t chain [NUM_CELLS+1];
    logic advance;
    logic out_valid_reg;
    logic [DATA_W-1:0] result_reg;
    logic cmp_reg;
    logic dz_reg;
    logic [DATA_W-1:0] final_res;

    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cell_out  (chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // The quotient lands in num; apply the sign and wrap to 32 bits.
    always_comb
    begin
        logic [QUO_W-1:0] q;
        q = chain[NUM_CELLS].neg ? (~chain[NUM_CELLS].num + QUO_W'(1))
                                 : chain[NUM_CELLS].num;
        final_res = chain[NUM_CELLS].is_div ? q[DATA_W-1:0] : chain[NUM_CELLS].res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= final_res;
            cmp_reg    <= chain[NUM_CELLS].cmp;
            dz_reg     <= chain[NUM_CELLS].dz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = result_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fpa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam int LATENCY = NUM_CELLS + 3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } alu_result_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        alu_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] opcode = '0;
    logic signed [DATA_W-1:0] operand_a = '0;
    logic signed [DATA_W-1:0] operand_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic compare_true;
    logic divide_by_zero;

    alu_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int cycles = 0;
    int div_zero_seen = 0;
    bit quiet_phase = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic alu_result_t alu_predict(opcode_t op, logic [31:0] a, logic [31:0] b);
        alu_result_t r;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [63:0] wide;
        sa = $signed(a);
        sb = $signed(b);
        r = '{32'd0, 1'b0, 1'b0};
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL:
            begin
                wide = sa * sb;
                r.value = 32'(wide >>> FRAC);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    wide = (sa <<< FRAC) / sb;
                    r.value = wide[31:0];
                end
            end
            OP_GT: r.cmp = sa > sb;
            OP_LT: r.cmp = sa < sb;
            OP_GE: r.cmp = sa >= sb;
            OP_LE: r.cmp = sa <= sb;
            OP_EQ: r.cmp = sa == sb;
            OP_NE: r.cmp = sa != sb;
            OP_MIN: r.value = (sa < sb) ? a : b;
            OP_MAX: r.value = (sa > sb) ? a : b;
            OP_INC: r.value = a + 32'd1;
            OP_DEC: r.value = a - 32'd1;
            OP_FROM_INT: r.value = a << FRAC;
            default: r.value = 32'(sa >>> FRAC);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'(signed'($urandom_range(0, 2048)) - 1024);
            3: return 32'($urandom_range(0, 4)) << FRAC;
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Drives one beat and waits until the block takes it.
    task automatic send_beat(opcode_t op, logic [31:0] a, logic [31:0] b,
                             logic known, alu_result_t typed);
        alu_result_t r;
        r = alu_predict(op, a, b);
        if (known && r != typed)
            $error("typed row disagrees with prediction for opcode %s", op.name());
        pending_results.push_back(known ? typed : r);
        in_valid <= 1'b1;
        opcode <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_off_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_value !== exp_r.value)
                begin
                    $error("result_value: expected %h, actual %h", exp_r.value, result_value);
                    errors++;
                end
                if (compare_true !== exp_r.cmp)
                begin
                    $error("compare_true: expected %b, actual %b", exp_r.cmp, compare_true);
                    errors++;
                end
                if (divide_by_zero !== exp_r.dz)
                begin
                    $error("divide_by_zero: expected %b, actual %b",
                           exp_r.dz, divide_by_zero);
                    errors++;
                end
                if (exp_r.dz)
                    div_zero_seen++;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        opcode_t op;
        int n;
        int wait_cycles;
        rows = '{
            '{OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
            '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
            '{OP_MUL, 32'h0000_0100, 32'h0000_0100, 1'b1, '{32'h0000_0100, 1'b0, 1'b0}},
            '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_MUL, 32'hffff_ffff, 32'h0000_0001, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
            '{OP_DIV, 32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1}},
            '{OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_DIV, 32'hffff_fffd, 32'h0000_0200, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_DIV, 32'h7fff_ffff, 32'h0000_0001, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_GT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
            '{OP_LT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0}},
            '{OP_GE, 32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0, 1'b1, 1'b0}},
            '{OP_LE, 32'h0000_0006, 32'h0000_0005, 1'b1, '{32'h0, 1'b0, 1'b0}},
            '{OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0}},
            '{OP_NE, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
            '{OP_MIN, 32'h0000_0007, 32'h0000_0007, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_MIN, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
            '{OP_MAX, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
            '{OP_MAX, 32'h0000_0009, 32'h0000_0009, 1'b0, '{32'h0, 1'b0, 1'b0}},
            '{OP_INC, 32'h7fff_ffff, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
            '{OP_DEC, 32'h8000_0000, 32'h0, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
            '{OP_FROM_INT, 32'h0080_0001, 32'h0, 1'b1, '{32'h8000_0100, 1'b0, 1'b0}},
            '{OP_TO_INT, 32'hffff_ff01, 32'h0, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
            '{OP_TO_INT, 32'h7fff_ffff, 32'h0, 1'b1, '{32'h007f_ffff, 1'b0, 1'b0}}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].res);
        // The block must fill up and push back while the receiver holds off.
        hold_off_req = 1'b1;
        n = 0;
        while (!hold_off_done)
        begin
            op = opcode_t'($urandom_range(0, 15));
            send_beat(op, random_operand(), random_operand(), 1'b0, '{32'h0, 1'b0, 1'b0});
            n++;
        end
        for (int i = 0; i < RANDOM_ITEMS - n; i++)
        begin
            if (i == RANDOM_ITEMS - n - 200)
                quiet_phase = 1'b1;
            op = opcode_t'($urandom_range(0, 15));
            send_beat(op, random_operand(),
                      ($urandom_range(0, 15) == 0) ? 32'd0 : random_operand(),
                      1'b0, '{32'h0, 1'b0, 1'b0});
            sender_gap();
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        wait_cycles = 2 * LATENCY;
        repeat (wait_cycles) @(posedge clk);
        $display("Checked %0d results over all 16 opcodes, %0d of them divides by zero.",
                 results_seen, div_zero_seen);
        $display("Random stalls on both sides and one long output hold-off were applied.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== fixed_point_alu.f =====
src/fpa_pkg.sv
src/fpa_cell.sv
src/fpa_front.sv
src/fixed_point_alu.sv
tb/tb.sv
